@@ design/fspa_pkg.sv @@
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared types and constants for the fixed slot pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fspa_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_DOUBLE = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      command_type        command;
      logic [SLOT_W-1:0]  slot_index;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  granted_index;
      logic [COUNT_W-1:0] live_slots;
      logic [COUNT_W-1:0] free_slots;
   } rsp_type;

   typedef struct packed {
      logic               clear;
      logic               rd_en;
      logic [SLOT_W-1:0]  stk_ra;
      logic [SLOT_W-1:0]  flg_ra;
      logic               stk_we;
      logic [SLOT_W-1:0]  stk_wa;
      logic [SLOT_W-1:0]  stk_wd;
      logic               flg_we;
      logic [SLOT_W-1:0]  flg_wa;
      logic               flg_wd;
   } mem_ctl_type;

endpackage

`default_nettype wire

@@ design/fspa_mem.sv @@
// ----------------------------------------------------------------------------
// fspa_mem
// Free stack and per-slot free flag memories with registered reads.
// Per-entry written bits give the initial contents without a clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_mem (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fspa_pkg::mem_ctl_type         ctl,
   input  wire logic [fspa_pkg::COUNT_W-1:0]  slot_count,
   output logic      [fspa_pkg::SLOT_W-1:0]   stack_top,
   output logic                               slot_free
);

   logic [fspa_pkg::SLOT_W-1:0]    stack_ram [fspa_pkg::MAX_SLOTS];
   logic                           flag_ram  [fspa_pkg::MAX_SLOTS];

   logic [fspa_pkg::MAX_SLOTS-1:0] stk_written_ff;
   logic [fspa_pkg::MAX_SLOTS-1:0] stk_written_in;
   logic [fspa_pkg::MAX_SLOTS-1:0] flg_written_ff;
   logic [fspa_pkg::MAX_SLOTS-1:0] flg_written_in;

   logic [fspa_pkg::SLOT_W-1:0]    stk_rdata_ff;
   logic [fspa_pkg::SLOT_W-1:0]    stk_ra_ff;
   logic                           stk_hit_ff;
   logic                           flg_rdata_ff;
   logic [fspa_pkg::SLOT_W-1:0]    flg_ra_ff;
   logic                           flg_hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.stk_we) begin
         stack_ram[ctl.stk_wa] <= ctl.stk_wd;
      end
      if (ctl.rd_en) begin
         stk_rdata_ff <= stack_ram[ctl.stk_ra];
         stk_hit_ff   <= stk_written_ff[ctl.stk_ra];
         stk_ra_ff    <= ctl.stk_ra;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.flg_we) begin
         flag_ram[ctl.flg_wa] <= ctl.flg_wd;
      end
      if (ctl.rd_en) begin
         flg_rdata_ff <= flag_ram[ctl.flg_ra];
         flg_hit_ff   <= flg_written_ff[ctl.flg_ra];
         flg_ra_ff    <= ctl.flg_ra;
      end
   end

   always_comb begin
      stk_written_in = stk_written_ff;
      flg_written_in = flg_written_ff;
      if (ctl.clear) begin
         stk_written_in = '0;
         flg_written_in = '0;
      end else begin
         if (ctl.stk_we) begin
            stk_written_in[ctl.stk_wa] = 1'b1;
         end
         if (ctl.flg_we) begin
            flg_written_in[ctl.flg_wa] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stk_written_ff <= '0;
         flg_written_ff <= '0;
      end else begin
         stk_written_ff <= stk_written_in;
         flg_written_ff <= flg_written_in;
      end
   end

   // unwritten stack entry i holds i; unwritten flag is set below slot_count
   assign stack_top = stk_hit_ff ? stk_rdata_ff : stk_ra_ff;
   assign slot_free = flg_hit_ff ? flg_rdata_ff : ({1'b0, flg_ra_ff} < slot_count);

endmodule

`default_nettype wire

@@ design/fixed_slot_pool_allocator_top.sv @@
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_top
// Fixed-size slot pool with a LIFO free stack and per-slot double-free check.
// ----------------------------------------------------------------------------
// For each request the free stack and free-flag memories are read in the
// cycle the request transfer completes, and the EXEC state then checks,
// updates and writes back, loading the response register. A new
// request is taken while the previous response waits; the update stalls only
// while a response is still held. Writing slot_count (0 reads as 1, above 64
// as 64) reinitialises the pool at once; no clearing pass is needed after
// reset.
`default_nettype none

module fixed_slot_pool_allocator_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire fspa_pkg::req_type             req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output fspa_pkg::rsp_type                  rsp_payload,
   input  wire logic                          csr_we,
   input  wire logic [fspa_pkg::COUNT_W-1:0]  csr_wdata
);

   fspa_pkg::state_type            state_ff, state_in;
   fspa_pkg::req_type              req_ff;
   logic [fspa_pkg::COUNT_W-1:0]   slot_count_ff, slot_count_in;
   logic [fspa_pkg::COUNT_W-1:0]   depth_ff, depth_in;
   logic [fspa_pkg::COUNT_W-1:0]   live_ff, live_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   fspa_pkg::rsp_type              rsp_ff, rsp_in;

   fspa_pkg::mem_ctl_type          ctl;
   logic [fspa_pkg::SLOT_W-1:0]    stack_top;
   logic                           slot_free;
   logic                           accept;
   logic                           exec_go;
   logic [fspa_pkg::COUNT_W-1:0]   csr_sat;

   fspa_mem u_mem (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .slot_count (slot_count_ff),
      .stack_top  (stack_top),
      .slot_free  (slot_free)
   );

   always_comb begin
      csr_sat = csr_wdata;
      if (csr_wdata == '0) begin
         csr_sat = fspa_pkg::COUNT_W'(1);
      end else if (csr_wdata > fspa_pkg::COUNT_W'(fspa_pkg::MAX_SLOTS)) begin
         csr_sat = fspa_pkg::COUNT_W'(fspa_pkg::MAX_SLOTS);
      end
   end

   always_comb begin
      state_in      = state_ff;
      slot_count_in = slot_count_ff;
      depth_in      = depth_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      req_ready     = 1'b0;
      exec_go       = 1'b0;

      ctl        = '0;
      ctl.stk_ra = depth_ff[fspa_pkg::SLOT_W-1:0] - fspa_pkg::SLOT_W'(1);
      ctl.flg_ra = req_payload.slot_index;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         fspa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.rd_en = 1'b1;
               state_in  = fspa_pkg::S_EXEC;
            end
         end
         fspa_pkg::S_EXEC: begin
            exec_go = !rsp_valid_ff || rsp_ready;
            if (exec_go) begin
               state_in             = fspa_pkg::S_IDLE;
               rsp_valid_in         = 1'b1;
               rsp_in.status        = fspa_pkg::ST_OK;
               rsp_in.granted_index = '0;
               if (req_ff.command == fspa_pkg::CMD_ALLOC) begin
                  if (depth_ff == '0) begin
                     rsp_in.status = fspa_pkg::ST_EMPTY;
                  end else begin
                     rsp_in.granted_index = stack_top;
                     ctl.flg_we = 1'b1;
                     ctl.flg_wa = stack_top;
                     ctl.flg_wd = 1'b0;
                     depth_in   = depth_ff - fspa_pkg::COUNT_W'(1);
                     live_in    = live_ff + fspa_pkg::COUNT_W'(1);
                  end
               end else begin
                  if ({1'b0, req_ff.slot_index} >= slot_count_ff) begin
                     rsp_in.status = fspa_pkg::ST_RANGE;
                  end else if (slot_free ||
                               depth_ff >= fspa_pkg::COUNT_W'(fspa_pkg::MAX_SLOTS)) begin
                     rsp_in.status = fspa_pkg::ST_DOUBLE;
                  end else begin
                     ctl.stk_we = 1'b1;
                     ctl.stk_wa = depth_ff[fspa_pkg::SLOT_W-1:0];
                     ctl.stk_wd = req_ff.slot_index;
                     ctl.flg_we = 1'b1;
                     ctl.flg_wa = req_ff.slot_index;
                     ctl.flg_wd = 1'b1;
                     depth_in   = depth_ff + fspa_pkg::COUNT_W'(1);
                     if (live_ff != '0) begin
                        live_in = live_ff - fspa_pkg::COUNT_W'(1);
                     end
                  end
               end
               rsp_in.live_slots = live_in;
               rsp_in.free_slots = depth_in;
            end
         end
         default: begin
            state_in = fspa_pkg::S_IDLE;
         end
      endcase

      if (csr_we) begin
         slot_count_in = csr_sat;
         depth_in      = csr_sat;
         live_in       = '0;
         ctl.clear     = 1'b1;
      end
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fspa_pkg::S_IDLE;
         slot_count_ff <= fspa_pkg::COUNT_W'(fspa_pkg::MAX_SLOTS);
         depth_ff      <= fspa_pkg::COUNT_W'(fspa_pkg::MAX_SLOTS);
         live_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         depth_ff      <= depth_in;
         live_ff       <= live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ design/fspa_checker.sv @@
// ----------------------------------------------------------------------------
// fspa_checker
// Port-level checks on the slot pool allocator responses.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire fspa_pkg::rsp_type             rsp_payload
);

   logic [fspa_pkg::COUNT_W:0] slot_sum;

   assign slot_sum = {1'b0, rsp_payload.live_slots} + {1'b0, rsp_payload.free_slots};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != fspa_pkg::ST_OK |->
         rsp_payload.granted_index == '0)
      else $error("failed request carries a granted index");

   a_empty_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == fspa_pkg::ST_EMPTY |->
         rsp_payload.free_slots == '0)
      else $error("empty status with free slots left");

   a_slot_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> slot_sum <= (fspa_pkg::COUNT_W + 1)'(fspa_pkg::MAX_SLOTS))
      else $error("live plus free slots exceed pool size");

endmodule

bind fixed_slot_pool_allocator_top fspa_checker u_fspa_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
